FILE: src/jsi_pkg.sv
// Shared types, constants and fixed-point helpers of the joint setpoint integrator.
`default_nettype none
package jsi_pkg;

	localparam logic [26:0] TURN    = 27'd105414357;
	localparam logic [29:0] RAD2DEG = 30'd961263669;
	localparam logic [31:0] RECIP   = 32'(64'h0400_0000_0000_0000 / 64'd105414357);

	typedef enum logic [4:0] {
		S_IDLE,
		S_SEED,
		S_SEED_DONE,
		S_STEP,
		S_SM,
		S_PROP,
		S_REQ,
		S_WRAP,
		S_WQ,
		S_WR,
		S_NEAR,
		S_LEAD,
		S_CLAMP,
		S_SETP,
		S_VMUL,
		S_VDIV,
		S_VWAIT,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		CFG_STEP_PERIOD = 2'd0,
		CFG_LEAD_LIMIT  = 2'd1,
		CFG_LEAD_ENABLE = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [31:0] divisor;
		logic [6:0]  iters;
	} div_cmd_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

	function automatic logic signed [31:0] sat_signed(input logic neg, input logic [63:0] m);
		logic signed [31:0] r;
		if (neg) begin
			if (m >= 64'h8000_0000) r = 32'sh8000_0000;
			else r = 32'sd0 - $signed(m[31:0]);
		end else begin
			if (m > 64'h7FFF_FFFF) r = 32'sh7FFF_FFFF;
			else r = $signed(m[31:0]);
		end
		return r;
	endfunction

	function automatic logic signed [31:0] deg_from_product(input logic neg, input logic [66:0] p);
		logic [66:0] s;
		s = p + 67'h8000_0000;
		return sat_signed(neg, {29'b0, s[66:32]});
	endfunction

	function automatic logic [34:0] deg_operand(input logic [39:0] mag);
		logic [34:0] r;
		if (mag > 40'h4_0000_0000) r = 35'h4_0000_0000;
		else r = mag[34:0];
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: src/jsi_channels.sv
// Channel interfaces of the joint setpoint integrator: requests, results and configuration.
`default_nettype none
interface jsi_req_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [2:0]         joint;
	logic signed [31:0] joint_velocity;
	logic signed [31:0] measured_position;
	modport source (output valid, req_type, joint, joint_velocity, measured_position,
		input ready);
	modport sink (input valid, req_type, joint, joint_velocity, measured_position,
		output ready);
endinterface

interface jsi_res_if;
	logic               valid;
	logic               ready;
	logic [2:0]         joint_out;
	logic signed [31:0] setpoint_deg;
	logic signed [31:0] velocity_deg;
	logic signed [31:0] proposed_deg;
	logic               lead_capped;
	modport source (output valid, joint_out, setpoint_deg, velocity_deg, proposed_deg,
		lead_capped, input ready);
	modport sink (input valid, joint_out, setpoint_deg, velocity_deg, proposed_deg,
		lead_capped, output ready);
endinterface

interface jsi_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/joint_setpoint_integrator.sv
// Top level of the joint setpoint integrator: sequencer, shared multiplier and joint store.
//
// Requests arrive on req; a seed beat copies measured_position into the joint's command,
// an apply beat integrates joint_velocity over step_period, wraps the measured angle to
// the nearest turn, applies the optional lead bound and clamps the move to the step.
// Each accepted request with a joint index below JOINTS yields one result beat on res;
// other indexes are dropped without a result.
// Configuration beats on cfg are always taken; write them only while the block is idle.
// The block holds one request at a time: req.ready is high only when idle.
// A seed result goes from S_SEED through S_SEED_DONE to S_OUT. An apply result is
// built from a sequence of steps on the one shared 35x32 multiplier, the turn wrap
// done by reciprocal multiplication, then the bit-serial divider for the 64-bit
// velocity quotient; with step_period zero the division is skipped.
// After each result beat the block returns to idle.
// The result is held in output registers until res.ready; a stalled receiver holds the
// block in its output state.
// Reset clears all commands to zero and loads the register reset values.
`default_nettype none
module joint_setpoint_integrator #(
	parameter int JOINTS = 7
) (
	input wire logic clk,
	input wire logic arst_n,
	jsi_cfg_if.sink  cfg,
	jsi_req_if.sink  req,
	jsi_res_if.source res
);

	localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	jsi_pkg::state_t state_q, state_d;

	logic [31:0] period_q;
	logic [30:0] lead_limit_q;
	logic        lead_en_q;

	logic signed [31:0] cmd_q [JOINTS];

	logic               req_q;
	logic [2:0]         joint_q;
	logic signed [31:0] vel_q, meas_q, prev_q, next_q;
	logic [35:0]        sm_q;
	logic signed [39:0] prop_q, near_q, lead_q, cand_q;
	logic               dneg_q;
	logic               qlsb_q;
	logic [26:0]        r_q;
	logic               qodd_q;
	logic signed [31:0] setp_q, veld_q, reqd_q;
	logic               lim_q;

	logic [34:0] mul_a;
	logic [31:0] mul_b;
	logic [66:0] mul_p_q;

	jsi_pkg::div_cmd_t div_cmd;
	jsi_pkg::div_rsp_t div_rsp;

	logic               in_range;
	logic [31:0]        vel_mag, meas_mag;
	logic [39:0]        prop_mag, d_mag, next_mag, lead_mag, sm_ext;
	logic signed [39:0] d, prev_ext, lo, hi, rr, rr_s, clamped;
	logic signed [32:0] diff;
	logic [32:0]        diff_mag;
	logic [39:0]        rw, rw_fix;
	logic               rw_ge;
	logic [27:0]        r2;
	logic               up;

	jsi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.rsp    (div_rsp)
	);

	assign in_range = 32'(req.joint) < JOINTS;
	assign cfg.ready = 1'b1;
	assign req.ready = state_q == jsi_pkg::S_IDLE;
	assign res.valid = state_q == jsi_pkg::S_OUT;
	assign res.joint_out     = joint_q;
	assign res.setpoint_deg  = setp_q;
	assign res.velocity_deg  = veld_q;
	assign res.proposed_deg  = reqd_q;
	assign res.lead_capped   = lim_q;

	always_comb begin
		vel_mag  = vel_q[31] ? 32'd0 - vel_q : vel_q;
		meas_mag = meas_q[31] ? 32'd0 - meas_q : meas_q;
		prev_ext = 40'(prev_q);
		sm_ext   = {4'b0, sm_q};
		prop_mag = prop_q[39] ? 40'd0 - prop_q : prop_q;
		d        = 40'(meas_q) - prop_q;
		d_mag    = d[39] ? 40'd0 - d : d;
		next_mag = next_q[31] ? 40'd0 - 40'(next_q) : 40'(next_q);
		diff     = 33'(next_q) - 33'(prev_q);
		diff_mag = diff[32] ? 33'd0 - diff : diff;
		rw       = d_mag - mul_p_q[39:0];
		rw_ge    = rw >= {13'b0, jsi_pkg::TURN};
		rw_fix   = rw - {13'b0, jsi_pkg::TURN};
		r2       = {r_q, 1'b0};
		up       = (r2 > {1'b0, jsi_pkg::TURN})
			|| ((r2 == {1'b0, jsi_pkg::TURN}) && qodd_q);
		rr       = up ? 40'(r_q) - 40'(jsi_pkg::TURN) : 40'(r_q);
		rr_s     = dneg_q ? 40'sd0 - rr : rr;
		lead_mag = lead_q[39] ? 40'd0 - lead_q : lead_q;
		lo       = prev_ext - $signed(sm_ext);
		hi       = prev_ext + $signed(sm_ext);
		if (cand_q < lo) clamped = lo;
		else if (cand_q > hi) clamped = hi;
		else clamped = cand_q;
	end

	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		div_cmd = '0;
		unique case (state_q)
			jsi_pkg::S_IDLE: begin
				if (req.valid && in_range) begin
					state_d = req.req_type ? jsi_pkg::S_STEP : jsi_pkg::S_SEED;
				end
			end
			jsi_pkg::S_SEED: begin
				mul_a   = {3'b0, meas_mag};
				mul_b   = {2'b0, jsi_pkg::RAD2DEG};
				state_d = jsi_pkg::S_SEED_DONE;
			end
			jsi_pkg::S_SEED_DONE: state_d = jsi_pkg::S_OUT;
			jsi_pkg::S_STEP: begin
				mul_a   = {3'b0, vel_mag};
				mul_b   = period_q;
				state_d = jsi_pkg::S_SM;
			end
			jsi_pkg::S_SM: state_d = jsi_pkg::S_PROP;
			jsi_pkg::S_PROP: state_d = jsi_pkg::S_REQ;
			jsi_pkg::S_REQ: begin
				mul_a   = jsi_pkg::deg_operand(prop_mag);
				mul_b   = {2'b0, jsi_pkg::RAD2DEG};
				state_d = jsi_pkg::S_WRAP;
			end
			jsi_pkg::S_WRAP: begin
				mul_a   = {3'b0, d_mag[35:4]};
				mul_b   = jsi_pkg::RECIP;
				state_d = jsi_pkg::S_WQ;
			end
			jsi_pkg::S_WQ: begin
				mul_a   = {25'b0, mul_p_q[63:54]};
				mul_b   = {5'b0, jsi_pkg::TURN};
				state_d = jsi_pkg::S_WR;
			end
			jsi_pkg::S_WR: state_d = jsi_pkg::S_NEAR;
			jsi_pkg::S_NEAR: state_d = jsi_pkg::S_LEAD;
			jsi_pkg::S_LEAD: state_d = jsi_pkg::S_CLAMP;
			jsi_pkg::S_CLAMP: state_d = jsi_pkg::S_SETP;
			jsi_pkg::S_SETP: begin
				mul_a   = jsi_pkg::deg_operand(next_mag);
				mul_b   = {2'b0, jsi_pkg::RAD2DEG};
				state_d = jsi_pkg::S_VMUL;
			end
			jsi_pkg::S_VMUL: begin
				mul_a   = {2'b0, diff_mag};
				mul_b   = {2'b0, jsi_pkg::RAD2DEG};
				state_d = jsi_pkg::S_VDIV;
			end
			jsi_pkg::S_VDIV: begin
				if (period_q == 32'd0) begin
					state_d = jsi_pkg::S_OUT;
				end else begin
					div_cmd.start    = 1'b1;
					div_cmd.dividend = mul_p_q[63:0] + {33'b0, period_q[31:1]};
					div_cmd.divisor  = period_q;
					div_cmd.iters    = 7'd64;
					state_d          = jsi_pkg::S_VWAIT;
				end
			end
			jsi_pkg::S_VWAIT: begin
				if (div_rsp.done) state_d = jsi_pkg::S_OUT;
			end
			jsi_pkg::S_OUT: begin
				if (res.ready) state_d = jsi_pkg::S_IDLE;
			end
			default: state_d = jsi_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= jsi_pkg::S_IDLE;
			period_q     <= 32'd4294967;
			lead_limit_q <= '0;
			lead_en_q    <= 1'b0;
			for (int i = 0; i < JOINTS; i++) cmd_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				unique case (jsi_pkg::cfg_idx_t'(cfg.index))
					jsi_pkg::CFG_STEP_PERIOD: period_q <= cfg.data;
					jsi_pkg::CFG_LEAD_LIMIT:  lead_limit_q <= cfg.data[30:0];
					jsi_pkg::CFG_LEAD_ENABLE: lead_en_q <= cfg.data[0];
					default: ;
				endcase
			end
			if (state_q == jsi_pkg::S_SEED_DONE) cmd_q[JW'(joint_q)] <= meas_q;
			if (state_q == jsi_pkg::S_SETP) cmd_q[JW'(joint_q)] <= next_q;
		end
	end

	always_ff @(posedge clk) begin
		mul_p_q <= 67'(mul_a) * 67'(mul_b);
		unique case (state_q)
			jsi_pkg::S_IDLE: begin
				if (req.valid && in_range) begin
					req_q   <= req.req_type;
					joint_q <= req.joint;
					vel_q   <= req.joint_velocity;
					meas_q  <= req.measured_position;
					prev_q  <= cmd_q[JW'(req.joint)];
				end
			end
			jsi_pkg::S_SEED_DONE: begin
				setp_q <= jsi_pkg::deg_from_product(meas_q[31], mul_p_q);
				reqd_q <= jsi_pkg::deg_from_product(meas_q[31], mul_p_q);
				veld_q <= '0;
				lim_q  <= 1'b0;
			end
			jsi_pkg::S_SM: begin
				sm_q <= 36'((mul_p_q + 67'h800_0000) >> 28);
			end
			jsi_pkg::S_PROP: begin
				prop_q <= vel_q[31] ? prev_ext - $signed(sm_ext) : prev_ext + $signed(sm_ext);
			end
			jsi_pkg::S_REQ: dneg_q <= d[39];
			jsi_pkg::S_WRAP: reqd_q <= jsi_pkg::deg_from_product(prop_q[39], mul_p_q);
			jsi_pkg::S_WQ: qlsb_q <= mul_p_q[54];
			jsi_pkg::S_WR: begin
				r_q    <= rw_ge ? rw_fix[26:0] : rw[26:0];
				qodd_q <= qlsb_q ^ rw_ge;
			end
			jsi_pkg::S_NEAR: begin
				near_q <= prop_q + rr_s;
				lead_q <= 40'sd0 - rr_s;
			end
			jsi_pkg::S_LEAD: begin
				if (lead_en_q && (lead_mag > 40'(lead_limit_q))) begin
					cand_q <= lead_q[39] ? near_q - 40'(lead_limit_q)
						: near_q + 40'(lead_limit_q);
					lim_q  <= 1'b1;
				end else begin
					cand_q <= prop_q;
					lim_q  <= 1'b0;
				end
			end
			jsi_pkg::S_CLAMP: begin
				if (clamped > 40'sh00_7FFF_FFFF) next_q <= 32'sh7FFF_FFFF;
				else if (clamped < -40'sh00_8000_0000) next_q <= 32'sh8000_0000;
				else next_q <= clamped[31:0];
			end
			jsi_pkg::S_VMUL: setp_q <= jsi_pkg::deg_from_product(next_q[31], mul_p_q);
			jsi_pkg::S_VDIV: begin
				if (period_q == 32'd0) veld_q <= '0;
			end
			jsi_pkg::S_VWAIT: begin
				if (div_rsp.done) veld_q <= jsi_pkg::sat_signed(diff[32], div_rsp.quotient);
			end
			default: ;
		endcase
	end

	a_idle_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && res.valid))
		else $error("request accepted while a result is pending");

	a_drop_range: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && !in_range) |=> req.ready)
		else $error("out of range joint did not return to idle");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == jsi_pkg::S_VWAIT))
		else $error("divider finished outside a wait state");

	a_seed_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == jsi_pkg::S_SEED) |-> !req_q)
		else $error("seed path entered for an apply request");

endmodule
`default_nettype wire

FILE: src/jsi_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module jsi_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire jsi_pkg::div_cmd_t cmd,
	output jsi_pkg::div_rsp_t      rsp
);

	logic [63:0] dvd_q;
	logic [31:0] rem_q;
	logic [31:0] dsr_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [32:0] reduced;
	logic        ge;

	assign shifted = {rem_q, dvd_q[63]};
	assign ge      = shifted >= {1'b0, dsr_q};
	assign reduced = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dvd_q <= cmd.dividend;
			dsr_q <= cmd.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? reduced[31:0] : shifted[31:0];
			dvd_q <= {dvd_q[62:0], ge};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;

endmodule
`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench of the joint setpoint integrator with a fixed-point predictor.
`default_nettype none

class setpoint_scoreboard;
	logic [31:0]        period;
	logic [30:0]        lead_max;
	logic               lead_on;
	logic signed [31:0] cmd [7];
	logic [99:0]        pending [$];
	int                 mismatches;

	function void clear();
		period = 32'd4294967;
		lead_max = '0;
		lead_on = 1'b0;
		foreach (cmd[i]) cmd[i] = '0;
		mismatches = 0;
	endfunction

	function void set_reg(jsi_pkg::cfg_idx_t idx, logic [31:0] d);
		case (idx)
			jsi_pkg::CFG_STEP_PERIOD: period = d;
			jsi_pkg::CFG_LEAD_LIMIT: lead_max = d[30:0];
			jsi_pkg::CFG_LEAD_ENABLE: lead_on = d[0];
			default: ;
		endcase
	endfunction

	function logic signed [31:0] clip(bit neg, longint unsigned m);
		if (neg) return (m >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(m[31:0]);
		return (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
	endfunction

	function longint unsigned absval(longint x);
		return x < 0 ? -x : x;
	endfunction

	function logic signed [31:0] to_deg(longint x);
		longint unsigned m;
		logic [127:0] p;
		m = absval(x);
		if (m > 64'h4_0000_0000) m = 64'h4_0000_0000;
		p = m * 128'd961263669 + 128'h8000_0000;
		return clip(x < 0, p[95:32]);
	endfunction

	function longint wrap(longint d);
		longint unsigned a, q, r;
		longint rr;
		a = absval(d);
		q = a / 105414357;
		r = a % 105414357;
		rr = r;
		if (2 * r > 105414357 || (2 * r == 105414357 && q[0])) rr -= 105414357;
		return d < 0 ? -rr : rr;
	endfunction

	function void note_request(bit kind, logic [2:0] j, logic signed [31:0] vel,
			logic signed [31:0] meas);
		logic signed [31:0] sp, vd, rq, nxt;
		bit lim;
		longint unsigned sm, q;
		longint prev, stp, prop, nr, ld, cand, diff;
		logic [127:0] num;
		if (j >= 7) return;
		vd = '0;
		lim = 0;
		if (!kind) begin
			cmd[j] = meas;
			sp = to_deg(meas);
			rq = sp;
		end else begin
			prev = cmd[j];
			sm = (absval(vel) * period + 64'd134217728) >> 28;
			stp = vel < 0 ? -longint'(sm) : longint'(sm);
			prop = prev + stp;
			nr = prop + wrap(longint'(meas) - prop);
			ld = prop - nr;
			cand = prop;
			rq = to_deg(prop);
			if (lead_on && absval(ld) > lead_max) begin
				cand = ld > 0 ? nr + lead_max : nr - lead_max;
				lim = 1;
			end
			if (cand < prev - longint'(sm)) cand = prev - longint'(sm);
			if (cand > prev + longint'(sm)) cand = prev + longint'(sm);
			nxt = cand > 64'sh7FFF_FFFF ? 32'sh7FFF_FFFF :
				cand < -64'sh8000_0000 ? 32'sh8000_0000 : cand[31:0];
			cmd[j] = nxt;
			sp = to_deg(nxt);
			if (period != 0) begin
				diff = longint'(nxt) - prev;
				num = absval(diff) * 128'd961263669;
				q = (num + period / 2) / period;
				vd = clip(diff < 0, q);
			end
		end
		pending.push_back({j, sp, vd, rq, lim});
	endfunction

	function void check_result(logic [99:0] got);
		logic [99:0] want;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result beat %h", got);
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: joint %0d/%0d setp %h/%h vel %h/%h req %h/%h lim %b/%b",
					want[99:97], got[99:97], want[96:65], got[96:65], want[64:33],
					got[64:33], want[32:1], got[32:1], want[0], got[0]);
		end
	endfunction
endclass

module tb;
	logic clk = 0;
	logic arst_n = 0;
	jsi_cfg_if cfg();
	jsi_req_if req();
	jsi_res_if res();
	setpoint_scoreboard sb;
	int idle_cycles;
	bit input_done;

	joint_setpoint_integrator u_dut (.clk(clk), .arst_n(arst_n), .cfg(cfg), .req(req),
		.res(res));

	always #5 clk = ~clk;

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 200);
	endfunction

	task automatic write_reg(jsi_pkg::cfg_idx_t idx, logic [31:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
		sb.set_reg(idx, d);
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_request(bit kind, logic [2:0] j, logic [31:0] v, logic [31:0] m,
			bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		repeat (g) @(negedge clk);
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.joint <= j;
		req.joint_velocity <= v;
		req.measured_position <= m;
		do @(posedge clk); while (!req.ready);
		sb.note_request(kind, j, v, m);
		@(negedge clk);
		req.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	function logic [31:0] rnd_edge();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return $urandom_range(0, 2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			sb.check_result({res.joint_out, res.setpoint_deg, res.velocity_deg,
				res.proposed_deg, res.lead_capped});
		if ((req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
			idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles > 20000) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		int g;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (input_done) res.ready <= 1'b1;
			else begin
				g = gap_len();
				if (g == 0) res.ready <= 1'b1;
				else begin
					res.ready <= 1'b0;
					repeat (g - 1) @(negedge clk);
				end
			end
		end
	end

	initial begin
		logic [31:0] periods [5];
		sb = new();
		sb.clear();
		idle_cycles = 0;
		input_done = 0;
		cfg.valid = 0; cfg.index = '0; cfg.data = '0;
		req.valid = 0; req.req_type = 0; req.joint = '0;
		req.joint_velocity = '0; req.measured_position = '0;
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_request(1, 0, 32'h0010_0000, 32'h0100_0000, 0);
		send_request(0, 1, 32'h0, 32'h7FFF_FFFF, 0);
		send_request(0, 2, 32'h0, 32'h8000_0000, 0);
		send_request(1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_request(1, 2, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_request(0, 7, 32'h0, 32'h1234_5678, 0);
		send_request(1, 7, 32'hFFFF_FFFF, 32'h0, 0);
		send_request(1, 6, 32'hFFFF_FFFF, 32'h0324_3F6A, 0);
		send_request(0, 3, 32'h0, 32'h0324_3F6B, 0);
		send_request(1, 3, 32'h0, 32'hFCDB_C095, 0);
		drain();
		write_reg(jsi_pkg::CFG_STEP_PERIOD, 32'h0);
		write_reg(jsi_pkg::CFG_LEAD_ENABLE, 32'h1);
		write_reg(jsi_pkg::CFG_LEAD_LIMIT, 32'h7FFF_FFFF);
		send_request(1, 1, 32'h7FFF_FFFF, 32'h0, 0);
		send_request(0, 4, 32'h0, 32'h0, 0);
		drain();
		write_reg(jsi_pkg::CFG_STEP_PERIOD, 32'hFFFF_FFFF);
		write_reg(jsi_pkg::CFG_LEAD_LIMIT, 32'h0);
		send_request(1, 4, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_request(1, 5, 32'h8000_0000, 32'h0, 0);
		send_request(1, 4, 32'h0010_0000, 32'h0000_1000, 0);
		drain();
		periods = '{32'd4294967, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd42949673};
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(jsi_pkg::CFG_STEP_PERIOD, ph < 5 ? periods[ph] : $urandom);
			write_reg(jsi_pkg::CFG_LEAD_LIMIT, $urandom_range(0, 3) == 0 ? $urandom >> 1 :
				$urandom_range(0, 1 << 24));
			write_reg(jsi_pkg::CFG_LEAD_ENABLE, {31'b0, ph[0]});
			for (int n = 0; n < 118; n++) begin
				if (n == 60) while (sb.pending.size() != 0) @(negedge clk);
				send_request($urandom_range(0, 3) != 0, ($urandom_range(0, 19) == 0) ? 3'd7 :
					3'($urandom_range(0, 6)), rnd_edge(), rnd_edge(), 1'b1);
			end
			drain();
		end
		input_done = 1;
		drain();
		if (sb.mismatches == 0 && sb.pending.size() == 0) $display("tb OK");
		else $display("tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
src/jsi_pkg.sv
src/jsi_channels.sv
src/jsi_div.sv
src/joint_setpoint_integrator.sv
test/tb.sv
